[sv/rmdu_pkg.sv]
// Shared types, constants and command codes for the multiply/divide unit.
package rmdu_pkg;

    localparam int XLEN       = 64;
    localparam int HALF       = XLEN / 2;
    localparam int WLEN       = 32;
    localparam int DIV_STEPS  = XLEN;
    localparam int MUL_STAGES = 3;
    localparam int MUL_DLY    = DIV_STEPS - MUL_STAGES;

    typedef enum logic [2:0] {
        CMD_MUL    = 3'd0,
        CMD_MULH   = 3'd1,
        CMD_MULHSU = 3'd2,
        CMD_MULHU  = 3'd3,
        CMD_DIV    = 3'd4,
        CMD_DIVU   = 3'd5,
        CMD_REM    = 3'd6,
        CMD_REMU   = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic word;
        logic ill;
        logic neg_q;
        logic neg_r;
        logic dz;
    } t_ctl;

    typedef struct packed {
        logic              valid;
        t_ctl              ctl;
        logic [XLEN:0]     rem;
        logic [XLEN-1:0]   quo;
        logic [XLEN-1:0]   dvs;
    } t_stage;

endpackage

[sv/rmdu_mul.sv]
// Three-stage multiplier giving the low or high half of the product.
module rmdu_mul (
    input  logic                      i_clk,
    input  logic                      i_adv,
    input  rmdu_pkg::t_cmd            i_cmd,
    input  logic [rmdu_pkg::XLEN-1:0] i_a,
    input  logic [rmdu_pkg::XLEN-1:0] i_b,
    output logic [rmdu_pkg::XLEN-1:0] o_res
);
    localparam int X = rmdu_pkg::XLEN;
    localparam int H = rmdu_pkg::HALF;

    logic [X-1:0]   r1_ll, r1_lh, r1_hl, r1_hh, r1_a, r1_b;
    rmdu_pkg::t_cmd r1_cmd, r2_cmd;
    logic [2*X-1:0] r2_prod, n2_prod;
    logic [X-1:0]   r2_ca, r2_cb, n2_ca, n2_cb, r3_res, n3_res;

    always_comb begin
        n2_prod = {r1_hh, r1_ll} + {{H{1'b0}}, r1_lh, {H{1'b0}}}
                + {{H{1'b0}}, r1_hl, {H{1'b0}}};
        n2_ca = ((r1_cmd == rmdu_pkg::CMD_MULH || r1_cmd == rmdu_pkg::CMD_MULHSU)
                 && r1_a[X-1]) ? r1_b : '0;
        n2_cb = (r1_cmd == rmdu_pkg::CMD_MULH && r1_b[X-1]) ? r1_a : '0;
    end

    always_comb begin
        if (r2_cmd == rmdu_pkg::CMD_MUL) begin
            n3_res = r2_prod[X-1:0];
        end else begin
            n3_res = r2_prod[2*X-1:X] - r2_ca - r2_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_ll   <= i_a[H-1:0] * i_b[H-1:0];
            r1_lh   <= i_a[H-1:0] * i_b[X-1:H];
            r1_hl   <= i_a[X-1:H] * i_b[H-1:0];
            r1_hh   <= i_a[X-1:H] * i_b[X-1:H];
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_cmd  <= i_cmd;
            r2_prod <= n2_prod;
            r2_ca   <= n2_ca;
            r2_cb   <= n2_cb;
            r2_cmd  <= r1_cmd;
            r3_res  <= n3_res;
        end
    end

    assign o_res = r3_res;
endmodule

[sv/rmdu_div_step.sv]
// One registered step of the restoring divider: one quotient bit per stage.
module rmdu_div_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  rmdu_pkg::t_stage i_stg,
    output rmdu_pkg::t_stage o_stg
);
    localparam int X = rmdu_pkg::XLEN;

    logic [X:0]       w_sh;
    logic [X+1:0]     w_diff;
    logic             w_ge;
    rmdu_pkg::t_stage n_stg, r_stg;
    logic             r_valid;

    always_comb begin
        w_sh   = {i_stg.rem[X-1:0], i_stg.quo[X-1]};
        w_diff = {1'b0, w_sh} - {2'b00, i_stg.dvs};
        w_ge   = ~w_diff[X+1];
        n_stg  = i_stg;
        n_stg.rem = w_ge ? w_diff[X:0] : w_sh;
        n_stg.quo = {i_stg.quo[X-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_stg.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stg <= n_stg;
        end
    end

    always_comb begin
        o_stg       = r_stg;
        o_stg.valid = r_valid;
    end
endmodule

[sv/rv64m_multiply_divide_unit_top.sv]
// Top level of the RISC-V M-extension multiply/divide unit.
// Every word passes 66 register stages: one operand preparation stage, 64
// restoring divider stages (one quotient bit each, which set the depth), and one
// result stage. The three-stage multiplier runs beside the divider chain and
// its result is delayed to match.
// A new word is accepted every cycle while the output side takes results; the
// whole pipeline holds when the output register is full and not taken.
module rv64m_multiply_divide_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic        i_word_mode,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result,
    output logic        o_illegal
);
    localparam int X = rmdu_pkg::XLEN;
    localparam int W = rmdu_pkg::WLEN;
    localparam int N = rmdu_pkg::DIV_STEPS;
    localparam int D = rmdu_pkg::MUL_DLY;

    logic             w_adv;
    rmdu_pkg::t_stage n_s0, r_s0;
    logic             r_s0_valid;
    logic [X-1:0]     n_ma, n_mb, r_ma, r_mb;
    logic [X-1:0]     w_mres;
    logic [X-1:0]     r_mdly [D];
    rmdu_pkg::t_stage w_stg [N+1];
    logic             r_valid, r_illegal;
    logic [X-1:0]     r_result, n_result;

    // Prepare operand magnitudes and sign corrections.
    always_comb begin
        logic [X-1:0] a, b;
        logic         sgn, na, nb;
        a   = i_operand_a[X-1:0];
        b   = i_operand_b[X-1:0];
        sgn = (rmdu_pkg::t_cmd'(i_command) == rmdu_pkg::CMD_DIV)
           || (rmdu_pkg::t_cmd'(i_command) == rmdu_pkg::CMD_REM);
        if (i_word_mode) begin
            a  = {{(X-W){1'b0}}, a[W-1:0]};
            b  = {{(X-W){1'b0}}, b[W-1:0]};
            na = sgn & a[W-1];
            nb = sgn & b[W-1];
            n_s0.quo = na ? {{(X-W){1'b0}}, -a[W-1:0]} : a;
            n_s0.dvs = nb ? {{(X-W){1'b0}}, -b[W-1:0]} : b;
        end else begin
            na = sgn & a[X-1];
            nb = sgn & b[X-1];
            n_s0.quo = na ? -a : a;
            n_s0.dvs = nb ? -b : b;
        end
        n_s0.valid     = i_valid;
        n_s0.rem       = '0;
        n_s0.ctl.cmd   = rmdu_pkg::t_cmd'(i_command);
        n_s0.ctl.word  = i_word_mode;
        n_s0.ctl.ill   = i_word_mode
            && (rmdu_pkg::t_cmd'(i_command) == rmdu_pkg::CMD_MULH
             || rmdu_pkg::t_cmd'(i_command) == rmdu_pkg::CMD_MULHSU
             || rmdu_pkg::t_cmd'(i_command) == rmdu_pkg::CMD_MULHU);
        n_s0.ctl.neg_q = na ^ nb;
        n_s0.ctl.neg_r = na;
        n_s0.ctl.dz    = (b == '0);
        n_ma = a;
        n_mb = b;
    end

    assign w_adv   = ~r_valid | i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_adv) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= n_s0;
            r_ma <= n_ma;
            r_mb <= n_mb;
        end
    end

    always_comb begin
        w_stg[0]       = r_s0;
        w_stg[0].valid = r_s0_valid;
    end

    for (genvar g = 0; g < N; g++) begin : g_div
        rmdu_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_stg   (w_stg[g]),
            .o_stg   (w_stg[g+1])
        );
    end

    rmdu_mul u_mul (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_cmd (r_s0.ctl.cmd),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .o_res (w_mres)
    );

    // Delay the product so that it lines up with the last divider stage.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mdly[0] <= w_mres;
            for (int k = 1; k < D; k++) begin
                r_mdly[k] <= r_mdly[k-1];
            end
        end
    end

    always_comb begin
        rmdu_pkg::t_stage s;
        logic [X-1:0]     r;
        s = w_stg[N];
        case (s.ctl.cmd)
            rmdu_pkg::CMD_DIV, rmdu_pkg::CMD_DIVU: begin
                r = s.ctl.dz ? '1 : (s.ctl.neg_q ? -s.quo : s.quo);
            end
            rmdu_pkg::CMD_REM, rmdu_pkg::CMD_REMU: begin
                r = s.ctl.neg_r ? -s.rem[X-1:0] : s.rem[X-1:0];
            end
            default: begin
                r = r_mdly[D-1];
            end
        endcase
        if (s.ctl.ill) begin
            n_result = '0;
        end else if (s.ctl.word) begin
            n_result = {{(X-W){r[W-1]}}, r[W-1:0]};
        end else begin
            n_result = r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= w_stg[N].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result  <= n_result;
            r_illegal <= w_stg[N].ctl.ill;
        end
    end

    assign o_valid   = r_valid;
    assign o_result  = r_result;
    assign o_illegal = r_illegal;
endmodule

[tb/rv64m_multiply_divide_unit_top_tb.sv]
// Self-checking testbench for the RV64 M-extension multiply/divide unit.
`timescale 1ns / 1ps

module rv64m_multiply_divide_unit_top_tb;

    localparam int LATENCY   = 70;
    localparam int WDOG_MAX  = 2000;

    typedef struct packed {
        logic [63:0] result;
        logic        illegal;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = rmdu_pkg::CMD_MUL;
    logic        i_word_mode = 1'b0;
    logic [63:0] i_operand_a = '0;
    logic [63:0] i_operand_b = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_result;
    logic        o_illegal;

    t_outcome pending_outcomes[$];
    int  fail_count = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  idle_cycles = 0;
    int  ready_hold = 0;
    bit  allow_idle = 1'b1;

    rv64m_multiply_divide_unit_top dut (.*);

    always #1 i_clk = ~i_clk;

    // Upper 64 bits of a product with the chosen operand signedness.
    function automatic logic [63:0] mul_upper(logic [63:0] a, logic [63:0] b,
                                              bit a_signed, bit b_signed);
        logic [127:0] ea, eb, p;
        ea = {{64{a_signed & a[63]}}, a};
        eb = {{64{b_signed & b[63]}}, b};
        p  = ea * eb;
        return p[127:64];
    endfunction

    function automatic t_outcome predict_muldiv(rmdu_pkg::t_cmd cmd, logic word,
                                                logic [63:0] a, logic [63:0] b);
        t_outcome o;
        logic [31:0] a32, b32, r32;
        logic [63:0] ma, mb, q;
        logic [31:0] ma32, mb32;
        o = '0;
        a32 = a[31:0];
        b32 = b[31:0];
        if (word) begin
            r32 = '0;
            ma32 = a32[31] ? -a32 : a32;
            mb32 = b32[31] ? -b32 : b32;
            case (cmd)
                rmdu_pkg::CMD_MUL:  r32 = a32 * b32;
                rmdu_pkg::CMD_DIV:  r32 = (b32 == 0) ? '1 :
                                ((a32[31] ^ b32[31]) ? -(ma32 / mb32) : ma32 / mb32);
                rmdu_pkg::CMD_DIVU: r32 = (b32 == 0) ? '1 : a32 / b32;
                rmdu_pkg::CMD_REM:  r32 = (b32 == 0) ? a32 :
                                (a32[31] ? -(ma32 % mb32) : ma32 % mb32);
                rmdu_pkg::CMD_REMU: r32 = (b32 == 0) ? a32 : a32 % b32;
                default:  o.illegal = 1'b1;
            endcase
            o.result = o.illegal ? 64'd0 : {{32{r32[31]}}, r32};
        end else begin
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            case (cmd)
                rmdu_pkg::CMD_MUL:    o.result = a * b;
                rmdu_pkg::CMD_MULH:   o.result = mul_upper(a, b, 1, 1);
                rmdu_pkg::CMD_MULHSU: o.result = mul_upper(a, b, 1, 0);
                rmdu_pkg::CMD_MULHU:  o.result = mul_upper(a, b, 0, 0);
                rmdu_pkg::CMD_DIV: begin
                    q = ma / mb;
                    o.result = (b == 0) ? '1 : ((a[63] ^ b[63]) ? -q : q);
                end
                rmdu_pkg::CMD_DIVU:   o.result = (b == 0) ? '1 : a / b;
                rmdu_pkg::CMD_REM:    o.result = (b == 0) ? a :
                                       (a[63] ? -(ma % mb) : ma % mb);
                default:    o.result = (b == 0) ? a : a % b;
            endcase
        end
        return o;
    endfunction

    // The valid line drops only where the sender actually pauses.
    task automatic random_idle();
        int n;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_word(rmdu_pkg::t_cmd cmd, logic word, logic [63:0] a,
                             logic [63:0] b);
        random_idle();
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_word_mode <= word;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_outcomes.push_back(predict_muldiv(cmd, word, a, b));
        words_sent++;
    endtask

    // Output side: back-pressure bursts and comparison against predictions.
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected word result=%h illegal=%b",
                             $time, o_result, o_illegal);
                    fail_count++;
                end else begin
                    exp_o = pending_outcomes.pop_front();
                    words_checked++;
                    if (exp_o.result !== o_result) begin
                        $display("%0t: result expected %h actual %h",
                                 $time, exp_o.result, o_result);
                        fail_count++;
                    end
                    if (exp_o.illegal !== o_illegal) begin
                        $display("%0t: illegal expected %b actual %b",
                                 $time, exp_o.illegal, o_illegal);
                        fail_count++;
                    end
                end
            end
            if (allow_idle && ready_hold > 0) begin
                ready_hold = ready_hold - 1;
                i_ready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 7) == 0) begin
                ready_hold = $urandom_range(0, 5);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'h8000_0000_0000_0000;
            3: return {32'h0, 32'h8000_0000};
            4: return {$urandom, 32'hFFFF_FFFF};
            5: return 64'($urandom_range(0, 9));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        logic [63:0] edge_vals[4];
        edge_vals = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'h7FFF_FFFF_FFFF_FFFF};
        for (int c = 0; c < 8; c++)
            send_word(rmdu_pkg::t_cmd'(c), 1'b0, edge_vals[c % 4],
                      edge_vals[(c + 1) % 4]);
        for (int c = 0; c < 8; c++)
            send_word(rmdu_pkg::t_cmd'(c), 1'b1, 64'h1234_5678_8000_0000,
                      64'hFFFF_FFFF);
        // Division by zero, remainder by zero, signed overflow and a negative dividend.
        send_word(rmdu_pkg::CMD_DIV,  1'b0, 64'h8000_0000_0000_0000, '1);
        send_word(rmdu_pkg::CMD_REM,  1'b0, 64'h8000_0000_0000_0000, '1);
        send_word(rmdu_pkg::CMD_DIVU, 1'b0, 64'd77, 64'd0);
        send_word(rmdu_pkg::CMD_REMU, 1'b1, 64'hDEAD_BEEF_9000_0001,
                  64'hABCD_0000_0000_0000);
        send_word(rmdu_pkg::CMD_DIV,  1'b1, 64'h8000_0000, 64'hFFFF_FFFF);
        send_word(rmdu_pkg::CMD_REM,  1'b1, 64'h8000_0000, 64'hFFFF_FFFF);
        send_word(rmdu_pkg::CMD_DIV,  1'b0, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_word(rmdu_pkg::t_cmd'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      pick_operand(), pick_operand());
            // Sender holds off once until the pipeline is empty.
            if (i == count / 2) drain();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1100);
        allow_idle = 1'b0;
        test_random(230);
        drain();
        repeat (LATENCY) @(posedge i_clk);
        $display("Sent %0d words over all commands in both widths, checked %0d.",
                 words_sent, words_checked);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[files.f]
sv/rmdu_pkg.sv
sv/rmdu_mul.sv
sv/rmdu_div_step.sv
sv/rv64m_multiply_divide_unit_top.sv
tb/rv64m_multiply_divide_unit_top_tb.sv
